[hdl/kmcq_pkg.sv]
package kmcq_pkg;

  localparam int MAX_POINTS   = 4096;
  localparam int MAX_CLUSTERS = 16;
  localparam int PADDR_W      = $clog2(MAX_POINTS);
  localparam int PCNT_W       = $clog2(MAX_POINTS + 1);
  localparam int CIDX_W       = $clog2(MAX_CLUSTERS);
  localparam int SUM_W        = 20;
  localparam int DIST_W       = 18;
  localparam int DSTEP_W      = 5;

  localparam logic [1:0] FUNC_POINT = 2'd0;
  localparam logic [1:0] FUNC_SEED  = 2'd1;
  localparam logic [1:0] FUNC_RUN   = 2'd2;

  localparam logic REG_CLUSTER_COUNT = 1'b0;
  localparam logic REG_MAX_ROUNDS    = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  cluster_index;
    logic [7:0]  center_red;
    logic [7:0]  center_green;
    logic [7:0]  center_blue;
    logic [12:0] member_count;
    logic        converged;
    logic        last;
  } out_word_t;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

endpackage

[hdl/kmeans_color_quantizer_core.sv]
// K-means color quantizer. Load RGB points with func 0 (one word per cycle, up to
// 4096; extra points are dropped), seed centroids with func 1, then send func 2 to
// run Lloyd rounds until no centroid moves or the round cap hits; the block then
// emits one word per cluster in index order with its member count. Each round
// runs the assignment walk over the point memory (one centroid distance per cycle
// through a single distance unit), then the centroid update (a shared 20-step
// restoring divider per channel). Input is stalled for the whole run.
module kmeans_color_quantizer_core
  import kmcq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_DIST = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_WB   = 4'd7;
  localparam logic [3:0] S_DEC  = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  logic [3:0]  state_q;
  logic [4:0]  cluster_count_q;
  logic [7:0]  max_rounds_q;
  logic [PCNT_W-1:0] point_total_q;
  logic [CIDX_W:0]   seed_ptr_q;
  logic [PCNT_W-1:0] pidx_q;
  logic [CIDX_W-1:0] j_q;
  logic [CIDX_W-1:0] kmax_q;
  logic [7:0]  round_q;
  logic [7:0]  cap_q;
  logic        changed_q;
  logic        conv_q;

  logic [23:0] centroid_q [MAX_CLUSTERS];
  logic [SUM_W-1:0]  sum_r_q [MAX_CLUSTERS];
  logic [SUM_W-1:0]  sum_g_q [MAX_CLUSTERS];
  logic [SUM_W-1:0]  sum_b_q [MAX_CLUSTERS];
  logic [PCNT_W-1:0] cnt_q   [MAX_CLUSTERS];

  logic [23:0] point_mem [MAX_POINTS];
  logic [23:0] pt_q;

  logic [DIST_W-1:0] dist_q;
  logic [CIDX_W-1:0] didx_q;
  logic              dvalid_q;
  logic [DIST_W-1:0] best_d_q;
  logic [CIDX_W-1:0] best_q;
  logic              best_take;
  logic [CIDX_W-1:0] best_n;
  logic [CIDX_W-1:0] acc_addr;

  logic [SUM_W-1:0] dq_r_q, dq_g_q, dq_b_q;
  logic [PCNT_W:0]  rem_r_q, rem_g_q, rem_b_q;
  logic [PCNT_W-1:0] div_n_q;
  logic [DSTEP_W-1:0] step_q;

  logic      out_valid_q;
  out_word_t out_q;

  logic      in_acc;
  logic      out_load;
  logic [23:0] cent_j;
  logic [23:0] new_cent;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign cent_j     = centroid_q[j_q];
  assign new_cent   = {dq_r_q[7:0], dq_g_q[7:0], dq_b_q[7:0]};

  assign best_take = dvalid_q && ((didx_q == '0) || (dist_q < best_d_q));
  assign best_n    = best_take ? didx_q : best_q;
  assign acc_addr  = (state_q == S_CMP) ? best_n : j_q;

  // point memory: one write port for loads, one registered read port for the walk
  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.func == FUNC_POINT && point_total_q < PCNT_W'(MAX_POINTS)) begin
      point_mem[point_total_q[PADDR_W-1:0]] <= {in_data_i.red, in_data_i.green, in_data_i.blue};
    end
    if (state_q == S_RD) begin
      pt_q <= point_mem[pidx_q[PADDR_W-1:0]];
    end
  end

  // distance stage and running minimum
  always_ff @(posedge clk_i) begin
    dist_q <= DIST_W'(sq_diff(pt_q[23:16], cent_j[23:16]))
            + DIST_W'(sq_diff(pt_q[15:8], cent_j[15:8]))
            + DIST_W'(sq_diff(pt_q[7:0], cent_j[7:0]));
    didx_q <= j_q;
    if (best_take) begin
      best_d_q <= dist_q;
      best_q   <= didx_q;
    end
  end

  // restoring dividers, one quotient bit per cycle
  function automatic logic [PCNT_W:0] div_rem(input logic [PCNT_W:0] rem,
                                              input logic msb,
                                              input logic [PCNT_W-1:0] n);
    logic [PCNT_W+1:0] t;
    t = {rem, msb} - {2'b00, n};
    return t[PCNT_W+1] ? {rem[PCNT_W-1:0], msb} : t[PCNT_W:0];
  endfunction

  function automatic logic div_bit(input logic [PCNT_W:0] rem,
                                   input logic msb,
                                   input logic [PCNT_W-1:0] n);
    logic [PCNT_W+1:0] t;
    t = {rem, msb} - {2'b00, n};
    return !t[PCNT_W+1];
  endfunction

  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) begin
      dq_r_q  <= sum_r_q[acc_addr];
      dq_g_q  <= sum_g_q[acc_addr];
      dq_b_q  <= sum_b_q[acc_addr];
      div_n_q <= cnt_q[acc_addr];
      rem_r_q <= '0;
      rem_g_q <= '0;
      rem_b_q <= '0;
    end else if (state_q == S_DIV) begin
      rem_r_q <= div_rem(rem_r_q, dq_r_q[SUM_W-1], div_n_q);
      rem_g_q <= div_rem(rem_g_q, dq_g_q[SUM_W-1], div_n_q);
      rem_b_q <= div_rem(rem_b_q, dq_b_q[SUM_W-1], div_n_q);
      dq_r_q  <= {dq_r_q[SUM_W-2:0], div_bit(rem_r_q, dq_r_q[SUM_W-1], div_n_q)};
      dq_g_q  <= {dq_g_q[SUM_W-2:0], div_bit(rem_g_q, dq_g_q[SUM_W-1], div_n_q)};
      dq_b_q  <= {dq_b_q[SUM_W-2:0], div_bit(rem_b_q, dq_b_q[SUM_W-1], div_n_q)};
    end
  end

  // accumulators
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) begin
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        sum_r_q[c] <= '0;
        sum_g_q[c] <= '0;
        sum_b_q[c] <= '0;
        cnt_q[c]   <= '0;
      end
    end else if (state_q == S_CMP) begin
      sum_r_q[acc_addr] <= sum_r_q[acc_addr] + SUM_W'(pt_q[23:16]);
      sum_g_q[acc_addr] <= sum_g_q[acc_addr] + SUM_W'(pt_q[15:8]);
      sum_b_q[acc_addr] <= sum_b_q[acc_addr] + SUM_W'(pt_q[7:0]);
      cnt_q[acc_addr]   <= cnt_q[acc_addr] + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      cluster_count_q <= 5'd8;
      max_rounds_q    <= 8'd64;
      point_total_q   <= '0;
      seed_ptr_q      <= '0;
      pidx_q          <= '0;
      j_q             <= '0;
      kmax_q          <= '0;
      round_q         <= '0;
      cap_q           <= '0;
      changed_q       <= 1'b0;
      conv_q          <= 1'b0;
      dvalid_q        <= 1'b0;
      step_q          <= '0;
      out_valid_q     <= 1'b0;
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        centroid_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CLUSTER_COUNT: cluster_count_q <= cfg_data_i[4:0];
          REG_MAX_ROUNDS:    max_rounds_q    <= cfg_data_i;
          default: ;
        endcase
      end

      dvalid_q <= (state_q == S_DIST);

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data_i.func)
              FUNC_POINT: begin
                if (point_total_q < PCNT_W'(MAX_POINTS)) begin
                  point_total_q <= point_total_q + 1'b1;
                end
              end
              FUNC_SEED: begin
                if (seed_ptr_q < (CIDX_W+1)'(MAX_CLUSTERS)) begin
                  centroid_q[seed_ptr_q[CIDX_W-1:0]] <=
                    {in_data_i.red, in_data_i.green, in_data_i.blue};
                  seed_ptr_q <= seed_ptr_q + 1'b1;
                end
              end
              FUNC_RUN: begin
                if (cluster_count_q == '0) begin
                  kmax_q <= '0;
                end else if (cluster_count_q > 5'(MAX_CLUSTERS)) begin
                  kmax_q <= CIDX_W'(MAX_CLUSTERS - 1);
                end else begin
                  kmax_q <= CIDX_W'(cluster_count_q - 1'b1);
                end
                cap_q   <= (max_rounds_q == '0) ? 8'd1 : max_rounds_q;
                round_q <= 8'd1;
                state_q <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          changed_q <= 1'b0;
          pidx_q    <= '0;
          j_q       <= '0;
          state_q   <= (point_total_q == '0) ? S_UPD : S_RD;
        end
        S_RD: begin
          j_q     <= '0;
          state_q <= S_DIST;
        end
        S_DIST: begin
          if (j_q == kmax_q) begin
            state_q <= S_CMP;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_CMP: begin
          pidx_q <= pidx_q + 1'b1;
          if (pidx_q + 1'b1 == point_total_q) begin
            j_q     <= '0;
            state_q <= S_UPD;
          end else begin
            state_q <= S_RD;
          end
        end
        S_UPD: begin
          // empty cluster: keep the centroid, skip the divide
          if (cnt_q[acc_addr] == '0) begin
            if (j_q == kmax_q) begin
              state_q <= S_DEC;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end else begin
            step_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == DSTEP_W'(SUM_W - 1)) begin
            state_q <= S_WB;
          end
        end
        S_WB: begin
          centroid_q[j_q] <= new_cent;
          if (new_cent != cent_j) begin
            changed_q <= 1'b1;
          end
          if (j_q == kmax_q) begin
            state_q <= S_DEC;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_UPD;
          end
        end
        S_DEC: begin
          j_q <= '0;
          if (!changed_q) begin
            conv_q  <= 1'b1;
            state_q <= S_EMIT;
          end else if (round_q >= cap_q) begin
            conv_q  <= 1'b0;
            state_q <= S_EMIT;
          end else begin
            round_q <= round_q + 1'b1;
            state_q <= S_CLR;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            if (j_q == kmax_q) begin
              point_total_q <= '0;
              seed_ptr_q    <= '0;
              state_q       <= S_IDLE;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.cluster_index <= j_q;
      out_q.center_red    <= cent_j[23:16];
      out_q.center_green  <= cent_j[15:8];
      out_q.center_blue   <= cent_j[7:0];
      out_q.member_count  <= cnt_q[acc_addr];
      out_q.converged     <= conv_q;
      out_q.last          <= (j_q == kmax_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/kmcq_checker.sv]
module kmcq_checker
  import kmcq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  // a run word blocks the input side on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.func == FUNC_RUN |=> in_stall_o)
    else $error("input not stalled after run word");

  // a word with the top cluster index is always the last one of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.cluster_index != 4'hF)
    else $error("cluster index overrun");

  // a reset clears the result valid
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid in reset");

endmodule

bind kmeans_color_quantizer_core kmcq_checker u_kmcq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[sim/kmcq_checker.sv]
module kmcq_scoreboard
  import kmcq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_word_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_word_t  out_data_i,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  logic [23:0]       pixels [MAX_POINTS];
  logic [CIDX_W-1:0] labels [MAX_POINTS];
  logic [23:0]       centers [MAX_CLUSTERS];
  int                pixel_total;
  int                seed_ptr;
  logic [4:0]        cluster_reg;
  logic [7:0]        round_cap_reg;
  out_word_t         expected_q[$];

  function automatic int color_dist(logic [23:0] p, logic [23:0] c);
    int dr, dg, db;
    dr = int'(p[23:16]) - int'(c[23:16]);
    dg = int'(p[15:8]) - int'(c[15:8]);
    db = int'(p[7:0]) - int'(c[7:0]);
    return dr * dr + dg * dg + db * db;
  endfunction

  // Lloyd rounds over the stored pixels, then queue one word per cluster
  task automatic run_kmeans();
    int k, cap, rnd, best, bestd, d, n, r, g, b;
    int counts[MAX_CLUSTERS];
    bit moved, conv, done;
    logic [23:0] nv;
    out_word_t w;
    k = (cluster_reg < 1) ? 1 : ((cluster_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : cluster_reg);
    cap = (round_cap_reg == 0) ? 1 : round_cap_reg;
    conv = 0;
    done = 0;
    rnd = 0;
    while (!done) begin
      rnd++;
      for (int i = 0; i < pixel_total; i++) begin
        best = 0;
        bestd = color_dist(pixels[i], centers[0]);
        for (int j = 1; j < k; j++) begin
          d = color_dist(pixels[i], centers[j]);
          if (d < bestd) begin
            bestd = d;
            best = j;
          end
        end
        labels[i] = best[CIDX_W-1:0];
      end
      moved = 0;
      for (int j = 0; j < k; j++) begin
        n = 0; r = 0; g = 0; b = 0;
        for (int i = 0; i < pixel_total; i++) begin
          if (labels[i] == j) begin
            n++;
            r += pixels[i][23:16];
            g += pixels[i][15:8];
            b += pixels[i][7:0];
          end
        end
        if (n != 0) begin
          nv = {8'(r / n), 8'(g / n), 8'(b / n)};
          if (nv != centers[j]) moved = 1;
          centers[j] = nv;
        end
      end
      if (!moved) begin
        conv = 1;
        done = 1;
      end else if (rnd >= cap) begin
        done = 1;
      end
    end
    foreach (counts[j]) counts[j] = 0;
    for (int i = 0; i < pixel_total; i++) counts[labels[i]]++;
    for (int j = 0; j < k; j++) begin
      w.cluster_index = j[3:0];
      w.center_red    = centers[j][23:16];
      w.center_green  = centers[j][15:8];
      w.center_blue   = centers[j][7:0];
      w.member_count  = counts[j][12:0];
      w.converged     = conv;
      w.last          = (j + 1 == k);
      expected_q = {expected_q, w};
    end
    pixel_total = 0;
    seed_ptr = 0;
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      foreach (centers[j]) centers[j] = '0;
      pixel_total = 0;
      seed_ptr = 0;
      cluster_reg = 5'd8;
      round_cap_reg = 8'd64;
      expected_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_CLUSTER_COUNT) cluster_reg = cfg_data_i[4:0];
        else round_cap_reg = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.func)
          FUNC_POINT: begin
            if (pixel_total < MAX_POINTS) begin
              pixels[pixel_total] = {in_data_i.red, in_data_i.green, in_data_i.blue};
              pixel_total++;
            end
          end
          FUNC_SEED: begin
            if (seed_ptr < MAX_CLUSTERS) begin
              centers[seed_ptr] = {in_data_i.red, in_data_i.green, in_data_i.blue};
              seed_ptr++;
            end
          end
          FUNC_RUN: run_kmeans();
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %p", $time, out_data_i);
          fail_count_o++;
        end else begin
          exp_w = expected_q.pop_front();
          check_field("cluster_index", exp_w.cluster_index, out_data_i.cluster_index);
          check_field("center_red", exp_w.center_red, out_data_i.center_red);
          check_field("center_green", exp_w.center_green, out_data_i.center_green);
          check_field("center_blue", exp_w.center_blue, out_data_i.center_blue);
          check_field("member_count", exp_w.member_count, out_data_i.member_count);
          check_field("converged", exp_w.converged, out_data_i.converged);
          check_field("last", exp_w.last, out_data_i.last);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

[sim/kmeans_color_quantizer_core_tb.sv]
module kmeans_color_quantizer_core_tb;
  import kmcq_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_CLUSTER_COUNT;
  logic [7:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         words_sent = 0;
  int         burst_left = 0;
  int         stall_mode = 0;
  int         stall_left = 0;

  always #5 clk_i = ~clk_i;

  kmeans_color_quantizer_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  kmcq_scoreboard u_scoreboard (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: switch between free flow, random stalls and heavy stalls
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [1:0] f, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_data <= '{func: f, red: r, green: g, blue: b};
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_random_pixel(input logic [1:0] f);
    send_word(f, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  // hold the sender until every expected word is back, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int k, npts, nseeds;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset config, no points: everything converges at once
    send_word(FUNC_RUN, 8'h00, 8'h00, 8'h00);
    send_word(FUNC_NONE, 8'hff, 8'hff, 8'hff);
    send_word(FUNC_SEED, 8'h00, 8'h00, 8'h00);
    send_word(FUNC_SEED, 8'h02, 8'h00, 8'h00);
    send_word(FUNC_SEED, 8'hff, 8'hff, 8'hff);
    send_word(FUNC_POINT, 8'h01, 8'h00, 8'h00);   // tie between first two seeds
    send_word(FUNC_POINT, 8'h00, 8'h00, 8'h00);
    send_word(FUNC_POINT, 8'hff, 8'hff, 8'hff);
    send_word(FUNC_POINT, 8'h80, 8'h7f, 8'h80);
    send_word(FUNC_RUN, 8'hff, 8'hff, 8'hff);
    settle();

    // seed overflow at the widest cluster setting
    write_reg(REG_CLUSTER_COUNT, 8'd16);
    write_reg(REG_MAX_ROUNDS, 8'd255);
    for (int i = 0; i < 17; i++) send_random_pixel(FUNC_SEED);
    for (int i = 0; i < 6; i++) send_random_pixel(FUNC_POINT);
    send_word(FUNC_RUN, 8'h00, 8'h00, 8'h00);
    settle();

    // out-of-range cluster counts and a zero round cap
    write_reg(REG_CLUSTER_COUNT, 8'd0);
    write_reg(REG_MAX_ROUNDS, 8'd0);
    for (int i = 0; i < 4; i++) send_random_pixel(FUNC_POINT);
    send_word(FUNC_RUN, 8'h00, 8'h00, 8'h00);
    settle();
    write_reg(REG_CLUSTER_COUNT, 8'd31);
    write_reg(REG_MAX_ROUNDS, 8'd1);
    for (int i = 0; i < 8; i++) send_random_pixel(FUNC_POINT);
    send_word(FUNC_RUN, 8'h00, 8'h00, 8'h00);
    settle();

    while (words_sent < 190) begin
      k = $urandom_range(0, 9);
      if (k == 0) k = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
      else k = $urandom_range(1, 16);
      write_reg(REG_CLUSTER_COUNT, k[7:0]);
      write_reg(REG_MAX_ROUNDS, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3))
                                                            : 8'($urandom_range(4, 64)));
      npts = $urandom_range(0, 20);
      nseeds = $urandom_range(0, 17);
      if ($urandom_range(0, 4) == 0) begin
        // noise: any function in any order
        for (int i = 0; i < npts + nseeds; i++) send_random_pixel(2'($urandom_range(0, 3)));
      end else begin
        for (int i = 0; i < npts; i++)
          send_random_pixel(($urandom_range(0, 15) == 0) ? FUNC_NONE : FUNC_POINT);
        for (int i = 0; i < nseeds; i++) send_random_pixel(FUNC_SEED);
      end
      send_random_pixel(FUNC_RUN);
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
hdl/kmcq_pkg.sv
hdl/kmeans_color_quantizer_core.sv
hdl/kmcq_checker.sv
sim/kmcq_checker.sv
sim/kmeans_color_quantizer_core_tb.sv
